[design/sliding_window_median_unit_assert.svh]
// Assertion macros for the sliding window median unit.
`ifndef SLIDING_WINDOW_MEDIAN_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that holds at every clock edge outside reset.
`define SWM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sliding window median: check failed");
// Condition that implies another in the following cycle.
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sliding window median: check failed");
`else
`define SWM_ASSERT_ALWAYS(lbl, cond)
`define SWM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/swm_pkg.sv]
// Shared constants and types of the sliding window median unit.
package swm_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int CFG_WIDTH        = 7;
  localparam logic [CFG_WIDTH-1:0] LEN_RESET = 7'd3;

  // Status a cell shows to its neighbors
  typedef struct packed {
    logic valid;  // cell holds a window sample
    logic gx;     // sample greater than incoming key, or cell empty
    logic del;    // cell at or above the leaving sample's slot
  } swm_flags_t;

endpackage

[design/swm_cell.sv]
// One cell of the sorted window: holds one sample and shifts with its neighbors.
module swm_cell #(
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           upd,
  input  logic                           clr,
  input  logic                           del_en,
  input  logic signed [SAMPLE_WIDTH-1:0] key,
  input  logic signed [SAMPLE_WIDTH-1:0] old_val,
  input  logic signed [SAMPLE_WIDTH-1:0] lo_val,
  input  swm_pkg::swm_flags_t            lo_flg,
  input  logic signed [SAMPLE_WIDTH-1:0] up_val,
  input  swm_pkg::swm_flags_t            up_flg,
  output logic signed [SAMPLE_WIDTH-1:0] val,
  output swm_pkg::swm_flags_t            flg
);
  import swm_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] val_r, val_nxt;
  logic                           valid_r, valid_nxt;
  logic                           grx_lo, grx_me;
  logic signed [SAMPLE_WIDTH-1:0] rlo_val, rme_val;
  logic                           rlo_v, rme_v;

  // Own status against the incoming and the leaving sample
  always_comb begin
    flg.valid = valid_r;
    flg.gx    = !valid_r || (val_r > key);
    flg.del   = del_en && valid_r && (val_r >= old_val);
  end

  // Window after removal, seen at this slot and the one below
  always_comb begin
    grx_lo  = lo_flg.del ? flg.gx : lo_flg.gx;
    rlo_val = lo_flg.del ? val_r : lo_val;
    rlo_v   = lo_flg.del ? valid_r : lo_flg.valid;
    grx_me  = flg.del ? up_flg.gx : flg.gx;
    rme_val = flg.del ? up_val : val_r;
    rme_v   = flg.del ? up_flg.valid : valid_r;
  end

  // Insert: shift up above the key's slot, take the key at it
  always_comb begin
    if (grx_lo) begin
      val_nxt   = rlo_val;
      valid_nxt = rlo_v;
    end else if (grx_me) begin
      val_nxt   = key;
      valid_nxt = 1'b1;
    end else begin
      val_nxt   = rme_val;
      valid_nxt = rme_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= 1'b0;
    end else if (upd) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

[design/swm_ring.sv]
// Arrival-order ring of samples; presents the sample that leaves next.
module swm_ring #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
  localparam int LW = $clog2(WINDOW_MAX + 1),
  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           upd,
  input  logic                           clr,
  input  logic [LW-1:0]                  len_eff,
  input  logic signed [SAMPLE_WIDTH-1:0] key,
  output logic signed [SAMPLE_WIDTH-1:0] old_val
);
  import swm_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] ring_mem [WINDOW_MAX];
  logic [PW-1:0]                  pos_r, pos_nxt;
  logic signed [SAMPLE_WIDTH-1:0] old_r;
  logic [LW-1:0]                  pos_inc;

  // Next write slot wraps at the window length
  always_comb begin
    pos_inc = LW'(pos_r) + LW'(1);
    pos_nxt = (pos_inc == len_eff) ? '0 : PW'(pos_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      pos_r <= '0;
    end else if (upd) begin
      pos_r <= pos_nxt;
    end
  end

  // Write the new sample, prefetch the one at the next slot
  always_ff @(posedge clk) begin
    if (upd) begin
      ring_mem[pos_r] <= key;
      old_r <= (pos_nxt == pos_r) ? key : ring_mem[pos_nxt];
    end
  end

  assign old_val = old_r;

endmodule

[design/sliding_window_median_unit.sv]
// Top level of the sliding window median unit: cell row, ring, fill and output.
// Each accepted sample updates the cell row; its median is then registered.
// Throughput: one sample per cycle; the sorted row updates as each is accepted.
// A result waiting behind a stalled output holds off the next sample.
// Reset (synchronous, rst_n low): window emptied, len_r back to 3, no output.
// Ring contents are not cleared; only written slots are ever used.
`include "sliding_window_median_unit_assert.svh"
module sliding_window_median_unit #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]    out_median,
  input  logic                              cfg_we,
  input  logic [swm_pkg::CFG_WIDTH-1:0]     cfg_wdata
);
  import swm_pkg::*;

  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [CFG_WIDTH-1:0]           len_r;
  logic [LW-1:0]                  len_eff;
  logic [LW-1:0]                  fill_r;
  logic                           full;
  logic                           owed;
  logic                           acc;
  logic                           pend_r;
  logic                           drain;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_median_r;
  logic signed [SAMPLE_WIDTH-1:0] old_val;
  logic [PW-1:0]                  med_idx;
  logic [LW-1:0]                  len_m1;
  logic signed [SAMPLE_WIDTH-1:0] cell_val [WINDOW_MAX];
  swm_flags_t                     cell_flg [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]          valid_vec;

  // Effective window length: zero acts as one, saturate at the cell count
  always_comb begin
    if (len_r == '0) begin
      len_eff = LW'(1);
    end else if (int'(len_r) > WINDOW_MAX) begin
      len_eff = LW'(WINDOW_MAX);
    end else begin
      len_eff = LW'(len_r);
    end
  end

  assign full    = (fill_r == len_eff);
  assign len_m1  = len_eff - LW'(1);
  assign med_idx = PW'(len_m1 >> 1);
  // The window is full once this sample is in
  assign owed    = full || (fill_r == len_m1);

  // Handshake: a waiting result moves out unless the output is blocked
  assign drain    = !out_valid_r || !out_stall;
  assign in_stall = pend_r && !drain;
  assign acc      = in_valid && !in_stall;

  // Window length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (cfg_we) begin
      len_r <= cfg_wdata;
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      fill_r <= '0;
    end else if (acc && !full) begin
      fill_r <= fill_r + LW'(1);
    end
  end

  // Arrival-order ring
  swm_ring #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (acc),
    .clr    (cfg_we),
    .len_eff(len_eff),
    .key    (in_sample),
    .old_val(old_val)
  );

  // Sorted row of cells, ascending from cell 0
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] lo_val, up_val;
    swm_flags_t                     lo_flg, up_flg;

    if (i == 0) begin : g_lo_edge
      assign lo_val = '0;
      assign lo_flg = '{valid: 1'b0, gx: 1'b0, del: 1'b0};
    end else begin : g_lo
      assign lo_val = cell_val[i-1];
      assign lo_flg = cell_flg[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_up_edge
      assign up_val = '0;
      assign up_flg = '{valid: 1'b0, gx: 1'b1, del: 1'b0};
    end else begin : g_up
      assign up_val = cell_val[i+1];
      assign up_flg = cell_flg[i+1];
    end

    swm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .upd    (acc),
      .clr    (cfg_we),
      .del_en (full),
      .key    (in_sample),
      .old_val(old_val),
      .lo_val (lo_val),
      .lo_flg (lo_flg),
      .up_val (up_val),
      .up_flg (up_flg),
      .val    (cell_val[i]),
      .flg    (cell_flg[i])
    );

    assign valid_vec[i] = cell_flg[i].valid;
  end

  // A result is owed for every sample that leaves the window full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (acc) begin
      pend_r <= owed;
    end else if (drain) begin
      pend_r <= 1'b0;
    end
  end

  // Output register, loaded from the median slot of the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (drain) begin
      out_valid_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (drain && pend_r) begin
      out_median_r <= cell_val[med_idx];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

  // Checks
  `SWM_ASSERT_ALWAYS(a_fill_le_len, fill_r <= len_eff)
  `SWM_ASSERT_ALWAYS(a_cells_match_fill, $countones(valid_vec) == int'(fill_r))
  `SWM_ASSERT_NEXT(a_full_owes_result, acc && full, pend_r)
  `SWM_ASSERT_NEXT(a_pend_reaches_out, pend_r && drain, out_valid_r)

endmodule
